FILE: rtl/rsd_pkg.sv
// Shared types, widths and helpers for the restoring signed divider.
// No dependencies; used by restoring_signed_divider and rsd_checker.
`timescale 1ns / 1ps

package rsd_pkg;

  // Bits of one operand magnitude; an operand carries one more bit for its sign.
  localparam int MagBits = 4;
  localparam int InBits  = MagBits + 1;

  // One pipeline stage for entry, then one stage for each quotient bit.
  localparam int Latency = MagBits + 1;

  typedef logic [MagBits-1:0] mag_t;
  typedef logic [InBits-1:0]  acc_t;
  typedef logic signed [InBits-1:0] operand_t;

  // Working set that travels down the divider pipeline.
  typedef struct packed {
    acc_t acc;      // partial remainder
    mag_t qr;       // dividend bits shifting out, quotient bits shifting in
    mag_t dvs;      // divisor magnitude
    logic q_neg;
    logic r_neg;
    logic dvz;
  } stage_t;

  // Magnitude of a two's complement operand. The most negative value has no
  // magnitude that fits, so it saturates to all ones.
  function automatic mag_t magnitude(input operand_t v);
    acc_t abs_v;
    abs_v = v[InBits-1] ? (~acc_t'(v) + acc_t'(1)) : acc_t'(v);
    return abs_v[InBits-1] ? '1 : abs_v[MagBits-1:0];
  endfunction

  // One restoring step: shift the pair left, trial-subtract, restore on borrow.
  function automatic stage_t div_step(input stage_t s);
    stage_t o;
    acc_t   acc_sh;
    o      = s;
    acc_sh = {s.acc[MagBits-1:0], s.qr[MagBits-1]};
    o.qr   = {s.qr[MagBits-2:0], 1'b0};
    if (acc_sh >= {1'b0, s.dvs}) begin
      o.acc   = acc_sh - {1'b0, s.dvs};
      o.qr[0] = 1'b1;
    end else begin
      o.acc = acc_sh;
    end
    return o;
  endfunction

endpackage

FILE: rtl/restoring_signed_divider.sv
// Pipelined signed divider by restoring division, sign-magnitude results.
// Depends on rsd_pkg for widths, the stage type and the step function.
`timescale 1ns / 1ps
//
//  Channel  Ports                                   Handshake
//  -------  --------------------------------------  -----------------------------
//  input    in_dividend, in_divisor                 start high and busy low
//  result   out_quotient_*, out_remainder_*,        out_valid high for one cycle
//           out_divide_by_zero
//
// A beat passes through the entry stage, which forms the magnitudes and signs,
// then through one stage per quotient bit.
// A new beat can enter on every cycle; busy is never raised.
// Synchronous active-low reset clears the valid bits only.
// Results cannot be stalled, so the pipeline never holds.

module restoring_signed_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rsd_pkg::operand_t     in_dividend,
  input  rsd_pkg::operand_t     in_divisor,
  output logic                  out_valid,
  output rsd_pkg::mag_t         out_quotient_magnitude,
  output logic                  out_quotient_negative,
  output rsd_pkg::mag_t         out_remainder_magnitude,
  output logic                  out_remainder_negative,
  output logic                  out_divide_by_zero
);

  logic [rsd_pkg::MagBits:0] vld_r;
  rsd_pkg::stage_t           stg_r   [rsd_pkg::MagBits+1];
  rsd_pkg::stage_t           stg_nxt [rsd_pkg::MagBits+1];
  rsd_pkg::stage_t           entry_nxt;
  logic                      dvd_zero;

  assign busy = 1'b0;

  // Entry stage: magnitudes and sign bits.
  assign dvd_zero = (in_dividend == '0);
  always_comb begin
    entry_nxt.acc   = '0;
    entry_nxt.qr    = rsd_pkg::magnitude(in_dividend);
    entry_nxt.dvs   = rsd_pkg::magnitude(in_divisor);
    entry_nxt.dvz   = (in_divisor == '0);
    entry_nxt.r_neg = in_dividend[rsd_pkg::InBits-1];
    entry_nxt.q_neg = !dvd_zero && (in_divisor != '0)
                      && (in_dividend[rsd_pkg::InBits-1] != in_divisor[rsd_pkg::InBits-1]);
  end

  assign stg_nxt[0] = entry_nxt;

  for (genvar k = 1; k <= rsd_pkg::MagBits; k++) begin : g_step
    assign stg_nxt[k] = rsd_pkg::div_step(stg_r[k-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[rsd_pkg::MagBits-1:0], start && !busy};
    end
  end

  for (genvar k = 0; k <= rsd_pkg::MagBits; k++) begin : g_reg
    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  assign out_valid               = vld_r[rsd_pkg::MagBits];
  assign out_quotient_magnitude  = stg_r[rsd_pkg::MagBits].qr;
  assign out_quotient_negative   = stg_r[rsd_pkg::MagBits].q_neg;
  assign out_remainder_magnitude = stg_r[rsd_pkg::MagBits].acc[rsd_pkg::MagBits-1:0];
  assign out_remainder_negative  = stg_r[rsd_pkg::MagBits].r_neg;
  assign out_divide_by_zero      = stg_r[rsd_pkg::MagBits].dvz;

endmodule

FILE: rtl/rsd_checker.sv
// Port-level checks for restoring_signed_divider, attached by bind.
// Depends on rsd_pkg for the latency and operand widths.
`timescale 1ns / 1ps

module rsd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rsd_pkg::operand_t in_dividend,
  input rsd_pkg::operand_t in_divisor,
  input logic              out_valid,
  input rsd_pkg::mag_t     out_quotient_magnitude,
  input logic              out_quotient_negative,
  input rsd_pkg::mag_t     out_remainder_magnitude,
  input logic              out_remainder_negative,
  input logic              out_divide_by_zero
);

  // Every accepted beat produces a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(rsd_pkg::Latency) out_valid)
    else $error("accepted beat produced no result");

  // No result appears without a matching accepted beat.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rsd_pkg::Latency))
    else $error("result without an accepted beat");

  // The remainder sign follows the dividend of the same beat.
  a_rem_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_remainder_negative
                   == $past(in_dividend[rsd_pkg::InBits-1], rsd_pkg::Latency)))
    else $error("remainder sign does not match dividend");

  // A zero divisor flags, saturates the quotient and gives a positive quotient.
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      ((out_quotient_magnitude == '1) && !out_quotient_negative))
    else $error("zero divisor result malformed");

  // The flag itself matches the divisor of the same beat.
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_divide_by_zero == ($past(in_divisor, rsd_pkg::Latency) == '0)))
    else $error("divide-by-zero flag does not match divisor");

endmodule

bind restoring_signed_divider rsd_checker u_rsd_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .start                   (start),
  .busy                    (busy),
  .in_dividend             (in_dividend),
  .in_divisor              (in_divisor),
  .out_valid               (out_valid),
  .out_quotient_magnitude  (out_quotient_magnitude),
  .out_quotient_negative   (out_quotient_negative),
  .out_remainder_magnitude (out_remainder_magnitude),
  .out_remainder_negative  (out_remainder_negative),
  .out_divide_by_zero      (out_divide_by_zero)
);

FILE: sim/restoring_signed_divider_test.sv
// Self-checking testbench for restoring_signed_divider: directed corner divisions,
// then random streams, each result checked field by field against a predicted quotient.
// Depends on rsd_pkg for operand and magnitude types and the pipeline latency.
`timescale 1ns / 1ps

module restoring_signed_divider_test;

  localparam int MaxMag      = (1 << rsd_pkg::MagBits) - 1;
  localparam int DrainLimit  = 1000;
  localparam int RunLimitNs  = 5_000_000;

  typedef struct {
    rsd_pkg::operand_t dividend;
    rsd_pkg::operand_t divisor;
    rsd_pkg::mag_t     quotient_mag;
    logic              quotient_neg;
    rsd_pkg::mag_t     remainder_mag;
    logic              remainder_neg;
    logic              div_by_zero;
  } division_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  rsd_pkg::operand_t in_dividend;
  rsd_pkg::operand_t in_divisor;
  logic              out_valid;
  rsd_pkg::mag_t     out_quotient_magnitude;
  logic              out_quotient_negative;
  rsd_pkg::mag_t     out_remainder_magnitude;
  logic              out_remainder_negative;
  logic              out_divide_by_zero;

  division_t expected_divisions[$];
  int        mismatch_count = 0;
  bit        gaps_enabled = 1'b1;

  restoring_signed_divider DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_dividend             (in_dividend),
    .in_divisor              (in_divisor),
    .out_valid               (out_valid),
    .out_quotient_magnitude  (out_quotient_magnitude),
    .out_quotient_negative   (out_quotient_negative),
    .out_remainder_magnitude (out_remainder_magnitude),
    .out_remainder_negative  (out_remainder_negative),
    .out_divide_by_zero      (out_divide_by_zero)
  );

  always #5 clk = ~clk;

  // Sign-magnitude division of two operands; the most negative operand
  // saturates to the largest magnitude, and a zero divisor gives an all-ones
  // quotient with the dividend magnitude left as remainder.
  function automatic division_t predict_division(rsd_pkg::operand_t dividend,
                                                 rsd_pkg::operand_t divisor);
    division_t d;
    int        num;
    int        den;
    num = (dividend < 0) ? -int'(dividend) : int'(dividend);
    den = (divisor < 0) ? -int'(divisor) : int'(divisor);
    if (num > MaxMag) num = MaxMag;
    if (den > MaxMag) den = MaxMag;
    d.dividend      = dividend;
    d.divisor       = divisor;
    d.div_by_zero   = (divisor == 0);
    d.remainder_neg = (dividend < 0);
    d.quotient_neg  = (dividend != 0) && (divisor != 0) && ((dividend < 0) != (divisor < 0));
    if (den == 0) begin
      d.quotient_mag  = rsd_pkg::mag_t'(MaxMag);
      d.remainder_mag = rsd_pkg::mag_t'(num);
    end else begin
      d.quotient_mag  = rsd_pkg::mag_t'(num / den);
      d.remainder_mag = rsd_pkg::mag_t'(num % den);
    end
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string field, division_t want, int got, int exp);
    if (got !== exp)
      report_mismatch($sformatf("%0d / %0d: %s got %0d, expected %0d",
                                want.dividend, want.divisor, field, got, exp));
  endtask

  // Every result beat is compared with the oldest outstanding division.
  always @(posedge clk) begin
    division_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_divisions.size() == 0) begin
        report_mismatch("result beat with no division outstanding");
      end else begin
        want = expected_divisions.pop_front();
        check_field("quotient_magnitude", want, int'(out_quotient_magnitude),
                    int'(want.quotient_mag));
        check_field("quotient_negative", want, int'(out_quotient_negative),
                    int'(want.quotient_neg));
        check_field("remainder_magnitude", want, int'(out_remainder_magnitude),
                    int'(want.remainder_mag));
        check_field("remainder_negative", want, int'(out_remainder_negative),
                    int'(want.remainder_neg));
        check_field("divide_by_zero", want, int'(out_divide_by_zero),
                    int'(want.div_by_zero));
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (!gaps_enabled) return 0;
    roll = int'($urandom_range(0, 99));
    if (roll < 50) return 0;
    if (roll < 85) return int'($urandom_range(1, 3));
    if (roll < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  // Corner values come up more often than a flat draw would give them.
  function automatic rsd_pkg::operand_t pick_operand();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 6) return rsd_pkg::operand_t'(-(MaxMag + 1));
    if (roll < 12) return rsd_pkg::operand_t'(0);
    if (roll < 16) return rsd_pkg::operand_t'(MaxMag);
    if (roll < 20) return rsd_pkg::operand_t'(-MaxMag);
    return rsd_pkg::operand_t'($urandom_range(0, (1 << rsd_pkg::InBits) - 1));
  endfunction

  // Drives one division beat, waits for it to be taken, then idles for a while.
  // With no gap, start simply stays high into the next beat.
  task automatic send_division(rsd_pkg::operand_t dividend, rsd_pkg::operand_t divisor);
    int gap;
    @(negedge clk);
    start       <= 1'b1;
    in_dividend <= dividend;
    in_divisor  <= divisor;
    do @(posedge clk); while (busy !== 1'b0);
    expected_divisions.push_back(predict_division(dividend, divisor));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start       <= 1'b0;
      in_dividend <= pick_operand();
      in_divisor  <= pick_operand();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    int cycles;
    cycles = 0;
    @(negedge clk);
    start <= 1'b0;
    while (expected_divisions.size() != 0 && cycles < DrainLimit) begin
      @(posedge clk);
      cycles++;
    end
    repeat (rsd_pkg::Latency + 2) @(posedge clk);
  endtask

  task automatic test_corner_divisions();
    send_division(rsd_pkg::operand_t'(MaxMag), rsd_pkg::operand_t'(1));
    send_division(rsd_pkg::operand_t'(-MaxMag), rsd_pkg::operand_t'(1));
    send_division(rsd_pkg::operand_t'(-(MaxMag + 1)), rsd_pkg::operand_t'(1));
    send_division(rsd_pkg::operand_t'(MaxMag), rsd_pkg::operand_t'(-(MaxMag + 1)));
    send_division(rsd_pkg::operand_t'(-(MaxMag + 1)), rsd_pkg::operand_t'(-(MaxMag + 1)));
    send_division(rsd_pkg::operand_t'(MaxMag), rsd_pkg::operand_t'(MaxMag));
    send_division(rsd_pkg::operand_t'(0), rsd_pkg::operand_t'(0));
    send_division(rsd_pkg::operand_t'(0), rsd_pkg::operand_t'(5));
    send_division(rsd_pkg::operand_t'(0), rsd_pkg::operand_t'(-3));
    send_division(rsd_pkg::operand_t'(7), rsd_pkg::operand_t'(0));
    send_division(rsd_pkg::operand_t'(-7), rsd_pkg::operand_t'(0));
    send_division(rsd_pkg::operand_t'(-(MaxMag + 1)), rsd_pkg::operand_t'(0));
    send_division(rsd_pkg::operand_t'(MaxMag), rsd_pkg::operand_t'(0));
    send_division(rsd_pkg::operand_t'(-9), rsd_pkg::operand_t'(3));
    send_division(rsd_pkg::operand_t'(-8), rsd_pkg::operand_t'(3));
    send_division(rsd_pkg::operand_t'(1), rsd_pkg::operand_t'(MaxMag));
    send_division(rsd_pkg::operand_t'(-1), rsd_pkg::operand_t'(-1));
    send_division(rsd_pkg::operand_t'(5), rsd_pkg::operand_t'(-2));
    send_division(rsd_pkg::operand_t'(10), rsd_pkg::operand_t'(-(MaxMag + 1)));
    send_division(rsd_pkg::operand_t'(-MaxMag), rsd_pkg::operand_t'(-MaxMag));
  endtask

  task automatic test_random_gapped(int count);
    repeat (count) send_division(pick_operand(), pick_operand());
  endtask

  // Full-rate stream: a beat enters on every cycle.
  task automatic test_random_back_to_back(int count);
    gaps_enabled = 1'b0;
    repeat (count) send_division(pick_operand(), pick_operand());
    gaps_enabled = 1'b1;
  endtask

  // Lets the pipeline empty completely before the stream picks up again.
  task automatic test_pause_until_drained(int count);
    test_random_gapped(count);
    wait_for_drain();
    test_random_back_to_back(count);
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_dividend = '0;
    in_divisor  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_divisions();
    test_random_back_to_back(200);
    test_random_gapped(300);
    test_pause_until_drained(60);
    test_random_gapped(110);
    wait_for_drain();
    repeat (rsd_pkg::Latency * 2) @(posedge clk);

    while (expected_divisions.size() != 0) begin
      division_t lost;
      lost = expected_divisions.pop_front();
      report_mismatch($sformatf("%0d / %0d: no result received", lost.dividend,
                                lost.divisor));
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
